/* hdl/odo_pkg.sv */
// Shared types, constants and helper functions of the wheel odometry block.
`timescale 1ns / 1ps

package odo_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_METRES_PER_TICK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_AXLE        = 2'd3;

    // Datapath widths
    localparam int MUL_A_W    = 64;
    localparam int MUL_B_W    = 36;
    localparam int DIV_W      = 64;
    localparam int TRIG_W     = 36;
    localparam int ANG_W      = 20;
    localparam int ACC_W      = 48;
    localparam int STEP_W     = 52;
    localparam int ATAN_IDX_W = 5;

    // Angle and scaling constants
    localparam logic signed [TRIG_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [TRIG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic signed [ANG_W:0]    PI_Q16      = 21'sd205887;
    localparam logic signed [ANG_W:0]    TWO_PI_Q16  = 21'sd411774;
    localparam logic signed [DIV_W-1:0]  TWO_PI_DIV  = 64'sd411774;
    localparam logic signed [MUL_B_W-1:0] US_PER_S   = 36'sd1000000;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE, ST_CORR, ST_MUL_DL, ST_MUL_DR, ST_LIN, ST_MUL_YAW, ST_MOD,
        ST_SC0, ST_MUL_SX, ST_MUL_SY, ST_SC1, ST_MUL_AX, ST_DIV_AX, ST_MUL_AY,
        ST_DIV_AY, ST_ACC, ST_MUL_LV, ST_DIV_LV, ST_MUL_AV, ST_DIV_AV, ST_OUT
    } odo_state_t;

    // Requests to and responses from the shared serial units
    typedef struct packed {
        logic                       start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [MUL_A_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIV_W-1:0] num;
        logic signed [DIV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIV_W-1:0] quot;
        logic signed [DIV_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic                     start;
        logic signed [ANG_W-1:0] angle;
    } trig_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [TRIG_W-1:0] sin;
        logic signed [TRIG_W-1:0] cos;
    } trig_rsp_t;

    // Arctangent of 2^-i in Q1.30 radians.
    function automatic logic [30:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        case (idx)
            5'd0:    return 31'd843314857;
            5'd1:    return 31'd497837829;
            5'd2:    return 31'd263043837;
            5'd3:    return 31'd133525159;
            5'd4:    return 31'd67021687;
            5'd5:    return 31'd33543516;
            5'd6:    return 31'd16775851;
            5'd7:    return 31'd8388437;
            5'd8:    return 31'd4194283;
            5'd9:    return 31'd2097149;
            5'd10:   return 31'd1048576;
            5'd11:   return 31'd524288;
            5'd12:   return 31'd262144;
            5'd13:   return 31'd131072;
            5'd14:   return 31'd65536;
            5'd15:   return 31'd32768;
            5'd16:   return 31'd16384;
            5'd17:   return 31'd8192;
            5'd18:   return 31'd4096;
            5'd19:   return 31'd2048;
            5'd20:   return 31'd1024;
            5'd21:   return 31'd512;
            5'd22:   return 31'd256;
            5'd23:   return 31'd128;
            default: return 31'd0;
        endcase
    endfunction

    // Saturate a 64-bit value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* hdl/odo_mul.sv */
// Shift-and-add signed multiplier that consumes one multiplier bit per cycle.
`timescale 1ns / 1ps

module odo_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  odo_pkg::mul_req_t req,
    output odo_pkg::mul_rsp_t rsp
);
    import odo_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_B_W-1:0] b_reg, b_next;
    logic [MUL_A_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [MUL_A_W-1:0] prod_reg, prod_next;

    // Magnitudes are loaded at start; each cycle adds the shifted multiplicand
    // for one multiplier bit, and a final step applies the sign.
    always_comb begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        prod_next = prod_reg;
        if (req.start) begin
            a_next    = req.a[MUL_A_W-1] ? -req.a : req.a;
            b_next    = req.b[MUL_B_W-1] ? -req.b : req.b;
            acc_next  = '0;
            neg_next  = req.a[MUL_A_W-1] ^ req.b[MUL_B_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
            fin_next  = 1'b0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_B_W - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            fin_next  = 1'b0;
            done_next = 1'b1;
            prod_next = neg_reg ? -acc_reg : acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = $signed(prod_reg);

endmodule

/* hdl/odo_div.sv */
// Restoring signed divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module odo_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  odo_pkg::div_req_t req,
    output odo_pkg::div_rsp_t rsp
);
    import odo_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             fin_reg, fin_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic             qneg_reg, qneg_next;
    logic             rneg_reg, rneg_next;
    logic [DIV_W-1:0] quot_out_reg, quot_out_next;
    logic [DIV_W-1:0] rem_out_reg, rem_out_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;

    // Partial remainder with the next dividend bit brought in.
    assign shifted = {rem_reg, num_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    // Quotient truncates toward zero; the remainder takes the dividend's sign.
    always_comb begin
        busy_next     = busy_reg;
        fin_next      = fin_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        qneg_next     = qneg_reg;
        rneg_next     = rneg_reg;
        quot_out_next = quot_out_reg;
        rem_out_next  = rem_out_reg;
        if (req.start) begin
            num_next  = req.num[DIV_W-1] ? -req.num : req.num;
            den_next  = req.den[DIV_W-1] ? -req.den : req.den;
            rem_next  = '0;
            q_next    = '0;
            qneg_next = req.num[DIV_W-1] ^ req.den[DIV_W-1];
            rneg_next = req.num[DIV_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
            fin_next  = 1'b0;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = trial[DIV_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            num_next = num_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            fin_next      = 1'b0;
            done_next     = 1'b1;
            quot_out_next = qneg_reg ? -q_reg : q_reg;
            rem_out_next  = rneg_reg ? -rem_reg : rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg      <= cnt_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        qneg_reg     <= qneg_next;
        rneg_reg     <= rneg_next;
        quot_out_reg <= quot_out_next;
        rem_out_reg  <= rem_out_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = $signed(quot_out_reg);
    assign rsp.rem  = $signed(rem_out_reg);

endmodule

/* hdl/odo_cordic.sv */
// Iterative rotation-mode CORDIC giving sine and cosine, one step per cycle.
`timescale 1ns / 1ps

module odo_cordic #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  odo_pkg::trig_req_t req,
    output odo_pkg::trig_rsp_t rsp
);
    import odo_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic                     busy_reg, busy_next;
    logic                     fin_reg, fin_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         step_reg, step_next;
    logic signed [TRIG_W-1:0] x_reg, x_next;
    logic signed [TRIG_W-1:0] y_reg, y_next;
    logic signed [TRIG_W-1:0] z_reg, z_next;
    logic                     flip_reg, flip_next;
    logic signed [TRIG_W-1:0] sin_reg, sin_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next;
    logic signed [TRIG_W-1:0] z_in;
    logic signed [TRIG_W-1:0] xs;
    logic signed [TRIG_W-1:0] ys;
    logic signed [TRIG_W-1:0] at;

    // Angle scaled from Q3.16 to Q5.30.
    assign z_in = TRIG_W'(req.angle) <<< 14;
    assign xs   = x_reg >>> step_reg;
    assign ys   = y_reg >>> step_reg;
    assign at   = $signed(TRIG_W'(atan_q30(ATAN_IDX_W'(step_reg))));

    // Fold into the right half plane, rotate, then undo the fold.
    always_comb begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        sin_next  = sin_reg;
        cos_next  = cos_reg;
        if (req.start) begin
            x_next    = GAIN_Q30;
            y_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
            fin_next  = 1'b0;
            if (z_in > HALF_PI_Q30) begin
                z_next    = z_in - PI_Q30;
                flip_next = 1'b1;
            end else if (z_in < -HALF_PI_Q30) begin
                z_next    = z_in + PI_Q30;
                flip_next = 1'b1;
            end else begin
                z_next    = z_in;
                flip_next = 1'b0;
            end
        end else if (busy_reg) begin
            if (!z_reg[TRIG_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            fin_next  = 1'b0;
            done_next = 1'b1;
            sin_next  = flip_reg ? -y_reg : y_reg;
            cos_next  = flip_reg ? -x_reg : x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
    end

    assign rsp.done = done_reg;
    assign rsp.sin  = sin_reg;
    assign rsp.cos  = cos_reg;

endmodule

/* hdl/differential_drive_odometry.sv */
// The first word after reset only captures reference counts.
// One word is worked on at a time; the rate is set by the shared serial multiplier
// and divider, plus the CORDIC.
// Reset (synchronous, active low) clears position, heading and reference counts
// and loads the default configuration.
`timescale 1ns / 1ps

module differential_drive_odometry #(
    parameter int COUNT_BITS   = 32,
    parameter int CORDIC_STEPS = 18
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [odo_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [odo_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [31:0]                         s_left_count,
    input  logic [31:0]                         s_right_count,
    input  logic [23:0]                         s_elapsed_us,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_pos_x,
    output logic signed [31:0]                  m_pos_y,
    output logic signed [18:0]                  m_heading,
    output logic signed [31:0]                  m_linear_velocity,
    output logic signed [31:0]                  m_angular_velocity,
    output logic                                m_time_zero
);
    import odo_pkg::*;

    // Configuration registers
    logic [32:0] enc_mod_reg;
    logic [31:0] wrap_thr_reg;
    logic [31:0] mpt_reg;
    logic [23:0] ial_reg;

    // Control and persistent state
    odo_state_t              state_reg, state_next;
    logic                    issued_reg;
    logic                    primed_reg;
    logic [COUNT_BITS-1:0]   last_left_reg, last_right_reg;
    logic signed [ACC_W-1:0] accum_x_reg, accum_y_reg;
    logic signed [ANG_W-1:0] yaw_reg;

    // Per-word working registers
    logic [COUNT_BITS-1:0]    lc_reg, rc_reg;
    logic [23:0]              el_reg;
    logic signed [35:0]       raw_l_reg, raw_r_reg;
    logic signed [31:0]       dlt_l_reg, dlt_r_reg;
    logic signed [31:0]       dl_reg, dr_reg, lin_reg;
    logic signed [32:0]       diff_reg;
    logic signed [41:0]       dyaw_reg;
    logic signed [ANG_W-1:0]  nyaw_reg;
    logic signed [TRIG_W-1:0] s0_reg, c0_reg, s1_reg, c1_reg;
    logic signed [STEP_W-1:0] dx_reg, dy_reg;
    logic signed [31:0]       lv_reg, av_reg;

    // Result word register
    logic                    m_valid_reg, m_valid_next;
    logic signed [31:0]      m_pos_x_reg, m_pos_y_reg, m_lv_reg, m_av_reg;
    logic signed [18:0]      m_heading_reg;
    logic                    m_tz_reg;

    // Shared units
    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    trig_req_t trig_req;
    trig_rsp_t trig_rsp;

    logic                    in_accept;
    logic                    out_load;
    logic                    unit_done;
    logic [COUNT_BITS-1:0]   lc_in, rc_in;
    logic signed [63:0]      rnd16, rnd30;
    logic signed [32:0]      pair_sum;
    logic signed [ANG_W:0]   rem21, wrapped;
    logic signed [52:0]      sum_x, sum_y;

    odo_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req), .rsp(mul_rsp));
    odo_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));
    odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(trig_req), .rsp(trig_rsp)
    );

    // Wrap correction and symmetric saturation of one count difference.
    function automatic logic signed [31:0] fix_delta(input logic signed [35:0] raw,
                                                     input logic [31:0] thr,
                                                     input logic [32:0] modv);
        logic signed [35:0] th;
        logic signed [35:0] md;
        logic signed [35:0] t;
        th = $signed(36'(thr));
        md = $signed(36'(modv));
        if (raw > th) begin
            t = raw - md;
        end else if (raw < -th) begin
            t = raw + md;
        end else begin
            t = raw;
        end
        if (t > 36'sd2147483647) begin
            return 32'sd2147483647;
        end else if (t < -36'sd2147483647) begin
            return -32'sd2147483647;
        end
        return t[31:0];
    endfunction

    // Saturate an accumulator sum to 48 bits.
    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [52:0] v);
        if (v > 53'sh0_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -53'sh0_8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end
        return v[ACC_W-1:0];
    endfunction

    assign in_accept = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign lc_in     = s_left_count[COUNT_BITS-1:0];
    assign rc_in     = s_right_count[COUNT_BITS-1:0];

    // Rounding of products back to Q.16 and from Q1.30.
    assign rnd16    = (mul_rsp.product + 64'sd32768) >>> 16;
    assign rnd30    = (mul_rsp.product + 64'sd536870912) >>> 30;
    assign pair_sum = 33'(dl_reg) + 33'(dr_reg);
    assign sum_x    = 53'(accum_x_reg) + 53'(dx_reg);
    assign sum_y    = 53'(accum_y_reg) + 53'(dy_reg);

    // Heading wrap into the interval of plus or minus pi.
    assign rem21 = div_rsp.rem[ANG_W:0];
    always_comb begin
        if (rem21 >= PI_Q16) begin
            wrapped = rem21 - TWO_PI_Q16;
        end else if (rem21 <= -PI_Q16) begin
            wrapped = rem21 + TWO_PI_Q16;
        end else begin
            wrapped = rem21;
        end
    end

    // Done flag of whichever unit the current state waits on.
    always_comb begin
        case (state_reg)
            ST_MUL_DL, ST_MUL_DR, ST_MUL_YAW, ST_MUL_SX, ST_MUL_SY,
            ST_MUL_AX, ST_MUL_AY, ST_MUL_LV, ST_MUL_AV: unit_done = mul_rsp.done;
            ST_MOD, ST_DIV_AX, ST_DIV_AY, ST_DIV_LV, ST_DIV_AV: unit_done = div_rsp.done;
            ST_SC0, ST_SC1: unit_done = trig_rsp.done;
            default: unit_done = 1'b0;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = primed_reg ? ST_CORR : ST_OUT;
                end
            end
            ST_CORR:    state_next = ST_MUL_DL;
            ST_MUL_DL:  if (unit_done) state_next = ST_MUL_DR;
            ST_MUL_DR:  if (unit_done) state_next = ST_LIN;
            ST_LIN:     state_next = ST_MUL_YAW;
            ST_MUL_YAW: if (unit_done) state_next = ST_MOD;
            ST_MOD:     if (unit_done) state_next = ST_SC0;
            ST_SC0: begin
                if (unit_done) begin
                    state_next = (dyaw_reg == '0) ? ST_MUL_SX : ST_SC1;
                end
            end
            ST_MUL_SX:  if (unit_done) state_next = ST_MUL_SY;
            ST_MUL_SY:  if (unit_done) state_next = ST_ACC;
            ST_SC1:     if (unit_done) state_next = ST_MUL_AX;
            ST_MUL_AX:  if (unit_done) state_next = ST_DIV_AX;
            ST_DIV_AX:  if (unit_done) state_next = ST_MUL_AY;
            ST_MUL_AY:  if (unit_done) state_next = ST_DIV_AY;
            ST_DIV_AY:  if (unit_done) state_next = ST_ACC;
            ST_ACC:     state_next = (el_reg == '0) ? ST_OUT : ST_MUL_LV;
            ST_MUL_LV:  if (unit_done) state_next = ST_DIV_LV;
            ST_DIV_LV:  if (unit_done) state_next = ST_MUL_AV;
            ST_MUL_AV:  if (unit_done) state_next = ST_DIV_AV;
            ST_DIV_AV:  if (unit_done) state_next = ST_OUT;
            ST_OUT:     if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: start pulses and operands for the shared units.
    always_comb begin
        mul_req  = '0;
        div_req  = '0;
        trig_req = '0;
        case (state_reg)
            ST_MUL_DL: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(dlt_l_reg);
                mul_req.b     = $signed(MUL_B_W'(mpt_reg));
            end
            ST_MUL_DR: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(dlt_r_reg);
                mul_req.b     = $signed(MUL_B_W'(mpt_reg));
            end
            ST_MUL_YAW: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(diff_reg);
                mul_req.b     = $signed(MUL_B_W'(ial_reg));
            end
            ST_MOD: begin
                div_req.start = !issued_reg;
                div_req.num   = DIV_W'(yaw_reg) + DIV_W'(dyaw_reg);
                div_req.den   = TWO_PI_DIV;
            end
            ST_SC0: begin
                trig_req.start = !issued_reg;
                trig_req.angle = yaw_reg;
            end
            ST_SC1: begin
                trig_req.start = !issued_reg;
                trig_req.angle = nyaw_reg;
            end
            ST_MUL_SX: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(lin_reg);
                mul_req.b     = c0_reg;
            end
            ST_MUL_SY: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(lin_reg);
                mul_req.b     = s0_reg;
            end
            ST_MUL_AX: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(lin_reg);
                mul_req.b     = s1_reg - s0_reg;
            end
            ST_MUL_AY: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(lin_reg);
                mul_req.b     = c1_reg - c0_reg;
            end
            ST_DIV_AX, ST_DIV_AY: begin
                div_req.start = !issued_reg;
                div_req.num   = mul_rsp.product;
                div_req.den   = DIV_W'(dyaw_reg) <<< 14;
            end
            ST_MUL_LV: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(lin_reg);
                mul_req.b     = US_PER_S;
            end
            ST_MUL_AV: begin
                mul_req.start = !issued_reg;
                mul_req.a     = MUL_A_W'(dyaw_reg);
                mul_req.b     = US_PER_S;
            end
            ST_DIV_LV, ST_DIV_AV: begin
                div_req.start = !issued_reg;
                div_req.num   = mul_rsp.product;
                div_req.den   = $signed(DIV_W'(el_reg));
            end
            default: begin
                mul_req  = '0;
                div_req  = '0;
                trig_req = '0;
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    // Control state, configuration and persistent odometry state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issued_reg     <= 1'b0;
            primed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            enc_mod_reg    <= 33'h1_0000_0000;
            wrap_thr_reg   <= 32'd1000000;
            mpt_reg        <= 32'd42950;
            ial_reg        <= 24'd131072;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            accum_x_reg    <= '0;
            accum_y_reg    <= '0;
            yaw_reg        <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (unit_done) begin
                issued_reg <= 1'b0;
            end else if (mul_req.start || div_req.start || trig_req.start) begin
                issued_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_ENC_MODULUS:     enc_mod_reg  <= cfg_wr_data;
                    CFG_WRAP_THRESHOLD:  wrap_thr_reg <= cfg_wr_data[31:0];
                    CFG_METRES_PER_TICK: mpt_reg      <= cfg_wr_data[31:0];
                    CFG_INV_AXLE:        ial_reg      <= cfg_wr_data[23:0];
                    default:             ial_reg      <= ial_reg;
                endcase
            end
            // The first word only captures the reference counts.
            if (in_accept && !primed_reg) begin
                primed_reg     <= 1'b1;
                last_left_reg  <= lc_in;
                last_right_reg <= rc_in;
            end
            if (state_reg == ST_ACC) begin
                accum_x_reg    <= sat48(sum_x);
                accum_y_reg    <= sat48(sum_y);
                yaw_reg        <= nyaw_reg;
                last_left_reg  <= lc_reg;
                last_right_reg <= rc_reg;
            end
        end
    end

    // Working registers of the word in flight.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            lc_reg    <= lc_in;
            rc_reg    <= rc_in;
            el_reg    <= s_elapsed_us;
            raw_l_reg <= $signed(36'(lc_in)) - $signed(36'(last_left_reg));
            raw_r_reg <= $signed(36'(rc_in)) - $signed(36'(last_right_reg));
            lv_reg    <= '0;
            av_reg    <= '0;
        end
        case (state_reg)
            ST_CORR: begin
                dlt_l_reg <= -fix_delta(raw_l_reg, wrap_thr_reg, enc_mod_reg);
                dlt_r_reg <= fix_delta(raw_r_reg, wrap_thr_reg, enc_mod_reg);
            end
            ST_MUL_DL:  if (mul_rsp.done) dl_reg <= sat32(rnd16);
            ST_MUL_DR:  if (mul_rsp.done) dr_reg <= sat32(rnd16);
            ST_LIN: begin
                lin_reg  <= pair_sum[32:1];
                diff_reg <= 33'(dr_reg) - 33'(dl_reg);
            end
            ST_MUL_YAW: if (mul_rsp.done) dyaw_reg <= rnd16[41:0];
            ST_MOD:     if (div_rsp.done) nyaw_reg <= wrapped[ANG_W-1:0];
            ST_SC0: begin
                if (trig_rsp.done) begin
                    s0_reg <= trig_rsp.sin;
                    c0_reg <= trig_rsp.cos;
                end
            end
            ST_SC1: begin
                if (trig_rsp.done) begin
                    s1_reg <= trig_rsp.sin;
                    c1_reg <= trig_rsp.cos;
                end
            end
            ST_MUL_SX:  if (mul_rsp.done) dx_reg <= rnd30[STEP_W-1:0];
            ST_MUL_SY:  if (mul_rsp.done) dy_reg <= rnd30[STEP_W-1:0];
            ST_DIV_AX:  if (div_rsp.done) dx_reg <= div_rsp.quot[STEP_W-1:0];
            ST_DIV_AY:  if (div_rsp.done) dy_reg <= -div_rsp.quot[STEP_W-1:0];
            ST_DIV_LV:  if (div_rsp.done) lv_reg <= sat32(div_rsp.quot);
            ST_DIV_AV:  if (div_rsp.done) av_reg <= sat32(div_rsp.quot);
            default:    dx_reg <= dx_reg;
        endcase
    end

    // Result word register, loaded when the previous word has been taken.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pos_x_reg   <= sat32(64'(accum_x_reg));
            m_pos_y_reg   <= sat32(64'(accum_y_reg));
            m_heading_reg <= yaw_reg[18:0];
            m_lv_reg      <= lv_reg;
            m_av_reg      <= av_reg;
            m_tz_reg      <= (el_reg == '0);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_pos_x            = m_pos_x_reg;
    assign m_pos_y            = m_pos_y_reg;
    assign m_heading          = m_heading_reg;
    assign m_linear_velocity  = m_lv_reg;
    assign m_angular_velocity = m_av_reg;
    assign m_time_zero        = m_tz_reg;

    // The stored heading always lies within minus pi to plus pi.
    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (yaw_reg <= 20'sd205887) && (yaw_reg >= -20'sd205887))
        else $error("heading left the wrapped range");

    // A word with zero elapsed time reports zero velocities.
    a_time_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_time_zero) |-> (m_linear_velocity == 0) && (m_angular_velocity == 0))
        else $error("velocity nonzero with zero elapsed time");

    // No new word is taken directly after one is accepted.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_ready)
        else $error("input accepted while a word is in flight");

endmodule
